// ----- rtl/microwire_eeprom_master_macros.svh -----
// Assertion macros shared by the microwire master RTL.
// ASSERT_CLK checks on every edge outside reset; ASSERT_ALWAYS also checks during reset.
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/mwem_pkg.sv -----
`default_nettype none

package mwem_pkg;

	localparam int ADDR_BITS = 6;
	localparam int DATA_BITS = 16;
	localparam int CMD_BITS  = 9;
	localparam int OUT_W     = CMD_BITS + DATA_BITS;
	localparam int BITS_W    = 5;
	localparam int HP_W      = 8;
	localparam int WAIT_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_ERAL  = 3'd2;
	localparam logic [2:0] KIND_EWEN  = 3'd3;
	localparam logic [2:0] KIND_EWDS  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_WAIT  = 2'd1;

	// command byte pieces: opcode in [7:6], extended code in [5:4]
	localparam logic [7:0] OP_READ  = 8'h80;
	localparam logic [7:0] OP_WRITE = 8'h40;
	localparam logic [7:0] OP_ERAL  = 8'h20;
	localparam logic [7:0] OP_EWEN  = 8'h30;
	localparam logic [7:0] OP_EWDS  = 8'h00;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SHIFT = 2'd1,
		PH_WAIT  = 2'd2
	} phase_t;

	typedef struct packed {
		logic                 req_valid;
		logic [2:0]           req_type;
		logic [ADDR_BITS-1:0] word_addr;
		logic [DATA_BITS-1:0] write_data;
		logic                 serial_in;
	} in_item_t;

	typedef struct packed {
		logic                 cs_level;
		logic                 serial_clock;
		logic                 serial_out;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_word;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/microwire_eeprom_master.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_data (in_item_t), one tick per beat
// out      output     out_valid / out_stall  out_data (out_item_t), one result per tick
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One tick per clock when not stalled: a beat is captured in the input register, stepped through the
// pin sequencer and lands in the output register.
// Throughput is set by the output register alone; a stall there holds the input register
// and raises in_stall in the same cycle. arst_n clears the sequencer, the handshake
// valids and the configuration (half period 1, ready wait 20000). cfg_ready is always high.
`default_nettype none
`include "microwire_eeprom_master_macros.svh"

module microwire_eeprom_master
	import mwem_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WAIT_W-1:0]    cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      adv;

	logic [HP_W-1:0]   half_period_q;
	logic [WAIT_W-1:0] ready_wait_q;

	phase_t               phase_q, phase_nxt;
	logic [2:0]           kind_q, kind_nxt;
	logic [OUT_W-1:0]     out_shift_q, out_shift_nxt;
	logic [DATA_BITS-1:0] in_shift_q, in_shift_nxt;
	logic [BITS_W-1:0]    bits_q, bits_nxt, bits_dec;
	logic                 clk_lvl_q, clk_lvl_nxt;
	logic [HP_W-1:0]      div_q, div_nxt, div_inc, hp;
	logic [WAIT_W-1:0]    wait_q, wait_nxt;
	logic [7:0]           cmd;
	logic                 done;
	out_item_t            res;

	// output slot frees when empty or being taken this cycle
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= 8'd1;
			ready_wait_q  <= 24'd20000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: half_period_q <= cfg_data[HP_W-1:0];
				CFG_READY_WAIT:  ready_wait_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			kind_q      <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			bits_q      <= '0;
			clk_lvl_q   <= 1'b0;
			div_q       <= '0;
			wait_q      <= '0;
		end else if (adv) begin
			phase_q     <= phase_nxt;
			kind_q      <= kind_nxt;
			out_shift_q <= out_shift_nxt;
			in_shift_q  <= in_shift_nxt;
			bits_q      <= bits_nxt;
			clk_lvl_q   <= clk_lvl_nxt;
			div_q       <= div_nxt;
			wait_q      <= wait_nxt;
		end
	end

	always_comb begin
		phase_nxt     = phase_q;
		kind_nxt      = kind_q;
		out_shift_nxt = out_shift_q;
		in_shift_nxt  = in_shift_q;
		bits_nxt      = bits_q;
		clk_lvl_nxt   = clk_lvl_q;
		div_nxt       = div_q;
		wait_nxt      = wait_q;
		done          = 1'b0;
		hp            = (half_period_q == '0) ? 8'd1 : half_period_q;
		div_inc       = div_q + 8'd1;
		bits_dec      = (bits_q != '0) ? bits_q - 5'd1 : '0;

		unique case (item_s1.req_type)
			KIND_READ:  cmd = OP_READ | {2'b00, item_s1.word_addr};
			KIND_WRITE: cmd = OP_WRITE | {2'b00, item_s1.word_addr};
			KIND_ERAL:  cmd = OP_ERAL;
			KIND_EWEN:  cmd = OP_EWEN;
			default:    cmd = OP_EWDS;
		endcase

		unique case (phase_q)
			PH_IDLE: begin
				if (item_s1.req_valid && item_s1.req_type <= KIND_EWDS) begin
					// start bit, command byte, then data bits for a write
					out_shift_nxt = {1'b1, cmd,
						(item_s1.req_type == KIND_WRITE) ? item_s1.write_data : 16'h0000};
					bits_nxt      = (item_s1.req_type == KIND_READ ||
						item_s1.req_type == KIND_WRITE) ? BITS_W'(OUT_W) : BITS_W'(CMD_BITS);
					kind_nxt      = item_s1.req_type;
					in_shift_nxt  = '0;
					clk_lvl_nxt   = 1'b0;
					div_nxt       = '0;
					phase_nxt     = PH_SHIFT;
				end
			end
			PH_SHIFT: begin
				div_nxt = div_inc;
				if (div_inc >= hp) begin
					div_nxt = '0;
					if (!clk_lvl_q) begin
						clk_lvl_nxt = 1'b1;
					end else begin
						// end of a clock-high half: sample, advance bit
						if (kind_q == KIND_READ && bits_q <= BITS_W'(DATA_BITS)) begin
							in_shift_nxt = {in_shift_q[DATA_BITS-2:0], item_s1.serial_in};
						end
						bits_nxt      = bits_dec;
						clk_lvl_nxt   = 1'b0;
						out_shift_nxt = {out_shift_q[OUT_W-2:0], 1'b0};
						if (bits_dec == '0) begin
							out_shift_nxt = '0;
							if (kind_q == KIND_WRITE || kind_q == KIND_ERAL) begin
								wait_nxt  = ready_wait_q;
								phase_nxt = PH_WAIT;
							end else begin
								phase_nxt = PH_IDLE;
								done      = 1'b1;
							end
						end
					end
				end
			end
			PH_WAIT: begin
				if (wait_q == '0) begin
					phase_nxt = PH_IDLE;
					done      = 1'b1;
				end else begin
					wait_nxt = wait_q - 24'd1;
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase

		res.cs_level     = (phase_nxt == PH_SHIFT);
		res.serial_clock = (phase_nxt == PH_SHIFT) && clk_lvl_nxt;
		res.serial_out   = (phase_nxt == PH_SHIFT) && out_shift_nxt[OUT_W-1];
		res.busy_res     = (phase_nxt != PH_IDLE);
		res.done_res     = done;
		res.read_word    = (done && kind_nxt == KIND_READ) ? in_shift_nxt : '0;
	end

	`ASSERT_CLK(a_done_idle, clk, arst_n,
		out_valid_q |-> !(out_q.done_res && out_q.busy_res), "done with busy still set")
	`ASSERT_CLK(a_clk_in_cs, clk, arst_n,
		out_valid_q && out_q.serial_clock |-> out_q.cs_level, "serial clock outside chip select")
	`ASSERT_CLK(a_cs_busy, clk, arst_n,
		out_valid_q && out_q.cs_level |-> out_q.busy_res, "chip select while not busy")
	`ASSERT_CLK(a_word_done, clk, arst_n,
		out_valid_q && (out_q.read_word != '0) |-> out_q.done_res, "read word outside done beat")
	`ASSERT_CLK(a_shift_bits, clk, arst_n,
		phase_q == PH_SHIFT |-> bits_q != '0, "shifting with no bits left")
	`ASSERT_ALWAYS(a_stall_held, clk,
		!valid_s1 |-> !in_stall, "stall raised with empty input register")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import mwem_pkg::*;

	typedef enum logic [1:0] {
		SIN_LOW,
		SIN_HIGH,
		SIN_TOGGLE,
		SIN_RANDOM
	} sin_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WAIT_W-1:0] cfg_data;

	// sequencer copy kept by the testbench
	logic [HP_W-1:0] half_ticks = 8'd1;
	logic [WAIT_W-1:0] wait_ticks = 24'd20000;
	phase_t seq_phase = PH_IDLE;
	logic [2:0] seq_kind = KIND_READ;
	logic [OUT_W-1:0] seq_out_bits = '0;
	logic [DATA_BITS-1:0] seq_in_bits = '0;
	logic [BITS_W-1:0] seq_bits_left = '0;
	logic seq_sck = 1'b0;
	logic [HP_W-1:0] seq_div = '0;
	logic [WAIT_W-1:0] seq_wait = '0;

	out_item_t pins_due[$];
	int mismatches = 0;
	int tick_count = 0;
	int hold_req = 0;
	int hold_left = 0;
	bit idle_on = 1'b1;

	microwire_eeprom_master u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// one tick of the pin sequencer; returns the pin levels after it
	function automatic out_item_t advance_sequencer(input in_item_t it);
		logic [HP_W-1:0] hp;
		logic [7:0] cmd;
		logic finished;
		out_item_t r;
		hp = (half_ticks == '0) ? 8'd1 : half_ticks;
		finished = 1'b0;
		case (seq_phase)
			PH_IDLE: begin
				if (it.req_valid && it.req_type <= KIND_EWDS) begin
					case (it.req_type)
						KIND_READ: cmd = OP_READ | {2'b00, it.word_addr};
						KIND_WRITE: cmd = OP_WRITE | {2'b00, it.word_addr};
						KIND_ERAL: cmd = OP_ERAL;
						KIND_EWEN: cmd = OP_EWEN;
						default: cmd = OP_EWDS;
					endcase
					// start bit, command byte, then data for a write
					seq_out_bits = {1'b1, cmd,
						(it.req_type == KIND_WRITE) ? it.write_data : 16'h0000};
					if (it.req_type == KIND_READ || it.req_type == KIND_WRITE)
						seq_bits_left = BITS_W'(OUT_W);
					else
						seq_bits_left = BITS_W'(CMD_BITS);
					seq_kind = it.req_type;
					seq_in_bits = '0;
					seq_sck = 1'b0;
					seq_div = '0;
					seq_phase = PH_SHIFT;
				end
			end
			PH_SHIFT: begin
				seq_div = seq_div + 8'd1;
				if (seq_div >= hp) begin
					seq_div = '0;
					if (!seq_sck) begin
						seq_sck = 1'b1;
					end else begin
						// read data is sampled at the end of each high half
						if (seq_kind == KIND_READ && seq_bits_left <= BITS_W'(DATA_BITS))
							seq_in_bits = {seq_in_bits[DATA_BITS-2:0], it.serial_in};
						if (seq_bits_left != '0)
							seq_bits_left = seq_bits_left - 5'd1;
						seq_sck = 1'b0;
						seq_out_bits = seq_out_bits << 1;
						if (seq_bits_left == '0) begin
							seq_out_bits = '0;
							if (seq_kind == KIND_WRITE || seq_kind == KIND_ERAL) begin
								seq_wait = wait_ticks;
								seq_phase = PH_WAIT;
							end else begin
								seq_phase = PH_IDLE;
								finished = 1'b1;
							end
						end
					end
				end
			end
			PH_WAIT: begin
				if (seq_wait == '0) begin
					seq_phase = PH_IDLE;
					finished = 1'b1;
				end else begin
					seq_wait = seq_wait - 24'd1;
				end
			end
			default: seq_phase = PH_IDLE;
		endcase
		r.cs_level = (seq_phase == PH_SHIFT);
		r.serial_clock = r.cs_level & seq_sck;
		r.serial_out = r.cs_level & seq_out_bits[OUT_W-1];
		r.busy_res = (seq_phase != PH_IDLE);
		r.done_res = finished;
		r.read_word = (finished && seq_kind == KIND_READ) ? seq_in_bits : '0;
		return r;
	endfunction

	function automatic logic pin_level(input sin_mode_t m);
		case (m)
			SIN_LOW: return 1'b0;
			SIN_HIGH: return 1'b1;
			SIN_TOGGLE: return tick_count[0];
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic in_item_t request_tick(input logic [2:0] kind,
		input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data,
		input sin_mode_t m);
		in_item_t it;
		it.req_valid = 1'b1;
		it.req_type = kind;
		it.word_addr = addr;
		it.write_data = data;
		it.serial_in = pin_level(m);
		return it;
	endfunction

	function automatic in_item_t quiet_tick(input sin_mode_t m);
		in_item_t it;
		it.req_valid = 1'b0;
		it.req_type = 3'($urandom_range(0, 7));
		it.word_addr = ADDR_BITS'($urandom_range(0, 63));
		it.write_data = DATA_BITS'($urandom_range(0, 65535));
		it.serial_in = pin_level(m);
		return it;
	endfunction

	// mostly a fresh request whenever the sequencer is free, some noise around it
	function automatic in_item_t random_tick(input bit wait_ops_ok);
		in_item_t it;
		int roll;
		it = quiet_tick(SIN_RANDOM);
		roll = $urandom_range(0, 99);
		if (seq_phase == PH_IDLE) begin
			if (roll < 85) begin
				it.req_valid = 1'b1;
				if (wait_ops_ok) begin
					it.req_type = 3'($urandom_range(KIND_READ, KIND_EWDS));
				end else begin
					case ($urandom_range(0, 2))
						0: it.req_type = KIND_READ;
						1: it.req_type = KIND_EWEN;
						default: it.req_type = KIND_EWDS;
					endcase
				end
			end else begin
				it.req_valid = 1'($urandom_range(0, 1));
				if (!wait_ops_ok && (it.req_type == KIND_WRITE || it.req_type == KIND_ERAL))
					it.req_valid = 1'b0;
			end
		end else begin
			it.req_valid = (roll < 10);
		end
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_tick(input in_item_t it);
		while (idle_on && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		pins_due.push_back(advance_sequencer(it));
		tick_count++;
		@(negedge clk);
	endtask

	// tick until the sequencer is free, then let every result drain
	task automatic run_to_idle(input sin_mode_t m);
		while (seq_phase != PH_IDLE)
			send_tick(quiet_tick(m));
		in_valid <= 1'b0;
		do @(negedge clk); while (pins_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic do_request(input logic [2:0] kind, input logic [ADDR_BITS-1:0] addr,
		input logic [DATA_BITS-1:0] data, input sin_mode_t m);
		send_tick(request_tick(kind, addr, data, m));
		run_to_idle(m);
	endtask

	task automatic configure(input logic [HP_W-1:0] hp, input logic [WAIT_W-1:0] rw);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= {16'h0000, hp};
		do @(posedge clk); while (cfg_ready !== 1'b1);
		half_ticks = hp;
		@(negedge clk);
		cfg_index <= CFG_READY_WAIT;
		cfg_data <= rw;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		wait_ticks = rw;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_config();
		do_request(KIND_EWEN, '0, '0, SIN_RANDOM);
		do_request(KIND_READ, 6'd0, '0, SIN_HIGH);
	endtask

	task automatic test_each_command();
		configure(8'd1, 24'd0);
		do_request(KIND_READ, 6'd63, '0, SIN_LOW);
		do_request(KIND_READ, 6'h2a, '0, SIN_TOGGLE);
		do_request(KIND_READ, 6'd0, '0, SIN_HIGH);
		do_request(KIND_WRITE, 6'd0, 16'h0000, SIN_RANDOM);
		do_request(KIND_WRITE, 6'd63, 16'hffff, SIN_RANDOM);
		do_request(KIND_WRITE, 6'h15, 16'ha5a5, SIN_RANDOM);
		do_request(KIND_ERAL, '0, '0, SIN_RANDOM);
		do_request(KIND_EWEN, '0, '0, SIN_RANDOM);
		do_request(KIND_EWDS, '0, '0, SIN_RANDOM);
	endtask

	task automatic test_ignored_requests();
		logic [2:0] kind;
		configure(8'd1, 24'd2);
		// undefined request codes leave the sequencer idle
		kind = KIND_EWDS;
		repeat (3) begin
			kind = kind + 3'd1;
			send_tick(request_tick(kind, ADDR_BITS'($urandom_range(0, 63)),
				DATA_BITS'($urandom), SIN_RANDOM));
		end
		send_tick(quiet_tick(SIN_RANDOM));
		// requests on every tick: those while busy and on the done tick are dropped
		repeat (60)
			send_tick(request_tick(3'($urandom_range(KIND_READ, KIND_EWDS)),
				ADDR_BITS'($urandom_range(0, 63)), DATA_BITS'($urandom), SIN_RANDOM));
		run_to_idle(SIN_RANDOM);
	endtask

	task automatic test_half_period_limits();
		configure(8'd0, 24'd1);
		do_request(KIND_READ, 6'h15, '0, SIN_RANDOM);
		do_request(KIND_ERAL, '0, '0, SIN_RANDOM);
		configure(8'd5, 24'd0);
		do_request(KIND_EWDS, '0, '0, SIN_RANDOM);
	endtask

	task automatic test_output_backpressure();
		configure(8'd1, 24'd2);
		idle_on = 1'b0;
		hold_req = 120;
		repeat (150)
			send_tick(random_tick(1'b1));
		idle_on = 1'b1;
		run_to_idle(SIN_RANDOM);
	endtask

	task automatic test_random_traffic(input logic [HP_W-1:0] hp,
		input logic [WAIT_W-1:0] rw, input int n, input bit wait_ops_ok, input bit gaps);
		configure(hp, rw);
		idle_on = gaps;
		repeat (n)
			send_tick(random_tick(wait_ops_ok));
		run_to_idle(SIN_RANDOM);
		idle_on = 1'b1;
	endtask

	// receiver side: random stalls plus an occasional long hold
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= idle_on && ($urandom_range(0, 99) < 16);
			end
		end
	end

	always @(posedge clk) begin : check_pins
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pins_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected", $realtime);
			end else begin
				want = pins_due.pop_front();
				if (want.cs_level !== out_data.cs_level
					|| want.serial_clock !== out_data.serial_clock
					|| want.serial_out !== out_data.serial_out
					|| want.busy_res !== out_data.busy_res
					|| want.done_res !== out_data.done_res
					|| want.read_word !== out_data.read_word) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: exp cs=%b sck=%b so=%b busy=%b done=%b word=%h, ",
							$realtime, want.cs_level, want.serial_clock,
							want.serial_out, want.busy_res, want.done_res,
							want.read_word);
						$display("got cs=%b sck=%b so=%b busy=%b done=%b word=%h",
							out_data.cs_level, out_data.serial_clock,
							out_data.serial_out, out_data.busy_res,
							out_data.done_res, out_data.read_word);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HALF_PERIOD;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_config();
		test_each_command();
		test_ignored_requests();
		test_half_period_limits();
		test_output_backpressure();
		test_random_traffic(8'd1, 24'd0, 100, 1'b1, 1'b0);
		test_random_traffic(8'd2, 24'd3, 60, 1'b1, 1'b1);
		test_random_traffic(8'd3, 24'd17, 60, 1'b1, 1'b1);
		// longest wait: only commands that do not wait are issued
		test_random_traffic(8'd3, 24'hffffff, 50, 1'b0, 1'b1);
		for (int n = 0; n < 2000 && pins_due.size() != 0; n++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pins_due.size() == 0)
			$display("microwire_eeprom_master: match");
		else
			$display("microwire_eeprom_master: mismatch");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("microwire_eeprom_master: mismatch");
		$finish;
	end

endmodule

// ----- microwire_eeprom_master.f -----
+incdir+rtl
rtl/mwem_pkg.sv
rtl/microwire_eeprom_master.sv
test/tb_top.sv
